@@ rtl/core/nmea_gga_position_parser_macros.svh @@
// Assertion macros used by the checker of the GGA position parser.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef NMEA_GGA_POSITION_PARSER_MACROS_SVH
`define NMEA_GGA_POSITION_PARSER_MACROS_SVH

// The consequent must hold at the same edge as the antecedent.
`define NGGA_ASSERT_NOW(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond_a) |-> (cond_b)) \
    else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define NGGA_ASSERT_NEXT(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond_a) |=> (cond_b)) \
    else $error(msg);

`endif

@@ rtl/core/ngga_pkg.sv @@
package ngga_pkg;

  // Field widths of the channels.
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned LAT_W  = 31;
  localparam int unsigned LON_W  = 32;

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_CHARS_DEF   = 127;
  localparam int unsigned FRAC_DIGITS_DEF = 5;

  // Sentence header and token numbering.
  localparam int unsigned HDR_LEN = 6;
  localparam int unsigned TOK_W   = 3;
  localparam logic [TOK_W-1:0] TOK_LAT  = 3'd2;
  localparam logic [TOK_W-1:0] TOK_NS   = 3'd3;
  localparam logic [TOK_W-1:0] TOK_LON  = 3'd4;
  localparam logic [TOK_W-1:0] TOK_EW   = 3'd5;
  localparam logic [TOK_W-1:0] TOK_LAST = 3'd7;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_G     = 8'h47;
  localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
  localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
  localparam logic [CHAR_W-1:0] CH_W     = 8'h57;

  // Raw accumulator, saturating at all ones.
  localparam int unsigned ACC_W = 34;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // Powers of ten up to the largest fraction width, and the largest
  // accumulator value that can be scaled by each without saturating.
  localparam int unsigned POW_W = 24;
  localparam logic [POW_W-1:0] POW10_TAB [8] = '{
    24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000, 24'd1000000, 24'd10000000
  };
  localparam logic [ACC_W-1:0] PAD_LIM_TAB [8] = '{
    ACC_MAX, ACC_MAX / 34'd10, ACC_MAX / 34'd100, ACC_MAX / 34'd1000,
    ACC_MAX / 34'd10000, ACC_MAX / 34'd100000, ACC_MAX / 34'd1000000,
    ACC_MAX / 34'd10000000
  };

  // Minutes scaled to 1e-7 degrees stay below 1e9, hence 30 bits.
  localparam int unsigned MR_W = 30;
  // Exact division by 60 for any 30-bit value: multiply and shift.
  localparam int unsigned DIV60_W  = 31;
  localparam logic [DIV60_W-1:0] DIV60_M = 31'd1145324613;
  localparam int unsigned DIV60_SH = 36;
  localparam int unsigned MIN_W    = 24;
  localparam logic [POW_W-1:0] E7 = 24'd10000000;

  // Magnitude limits of the two coordinates.
  localparam int unsigned LANES = 2;
  localparam int unsigned MAG_W = 31;
  localparam int LAT_RANGE = 900000000;
  localparam int LON_RANGE = 1800000000;
  localparam logic [MAG_W-1:0] LIM_TAB [LANES] = '{MAG_W'(LAT_RANGE), MAG_W'(LON_RANGE)};

  // Expected header character at each of the first six positions.
  function automatic logic [CHAR_W-1:0] hdr_char(input logic [2:0] idx);
    logic [CHAR_W-1:0] ch;
    unique case (idx)
      3'd0:    ch = CH_DOLLAR;
      3'd1:    ch = CH_G;
      3'd2:    ch = CH_P;
      3'd3:    ch = CH_G;
      3'd4:    ch = CH_G;
      3'd5:    ch = CH_A;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/ngga_if.sv @@
// Character channel into the parser.
interface ngga_in_if;
  import ngga_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              last;

  modport source (output valid, output char_byte, output last, input ready);
  modport sink   (input valid, input char_byte, input last, output ready);
endinterface

// Position channel out of the parser.
interface ngga_out_if;
  import ngga_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    updated;
  logic signed [LAT_W-1:0] latitude_e7;
  logic signed [LON_W-1:0] longitude_e7;

  modport source (output valid, output updated, output latitude_e7, output longitude_e7,
                  input ready);
  modport sink   (input valid, input updated, input latitude_e7, input longitude_e7,
                  output ready);
endinterface

@@ rtl/core/nmea_gga_position_parser.sv @@
// Channel | Dir | Payload                                  | Items
// in_i    | in  | char_byte[7:0], last                     | one per character
// out_o   | out | updated, latitude_e7[30:0], longitude_e7 | one per last character
//
// One character is taken in every cycle in which the output is not stalled; an accepted
// character is held in the input register and updates the sentence state from there. A last
// character produces its result through the eight-stage conversion line (scaling, division by
// the degree unit, minutes to 1e-7 degrees, saturation) behind the input register.
// A result that is not taken holds the whole line: in_i.ready = !out_o.valid || out_o.ready.
// Asynchronous reset returns the sentence state to its start, clears the line valid bits and sets the position to zero.
module nmea_gga_position_parser #(
  parameter int unsigned MAX_CHARS   = ngga_pkg::MAX_CHARS_DEF,
  parameter int unsigned FRAC_DIGITS = ngga_pkg::FRAC_DIGITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ngga_in_if.sink    in_i,
  ngga_out_if.source out_o
);
  import ngga_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_CHARS + 1);
  localparam int unsigned SEEN_W = $clog2(FRAC_DIGITS + 1);
  localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_CHARS);
  localparam logic [CNT_W-1:0]  HDR_CNT  = CNT_W'(HDR_LEN);
  localparam logic [SEEN_W-1:0] FRAC_CNT = SEEN_W'(FRAC_DIGITS);

  // One degree in raw units, and its reciprocal scaled by 2^ACC_W.
  localparam logic [63:0] UNIT   = 64'd100 * 64'(POW10_TAB[FRAC_DIGITS]);
  localparam logic [63:0] DIV_M  = (64'd1 << ACC_W) / UNIT;
  localparam logic [63:0] Q_MAX  = 64'(ACC_MAX) / UNIT;
  localparam int unsigned DIVM_W = $clog2(DIV_M + 64'd1);
  localparam int unsigned Q_W    = $clog2(Q_MAX + 64'd1);
  localparam int unsigned REM_W  = $clog2(UNIT);
  localparam logic [POW_W-1:0] P7F = POW10_TAB[7 - FRAC_DIGITS];
  localparam int unsigned QE_W   = Q_W + POW_W;
  localparam int unsigned V_W    = QE_W + 1;
  localparam int unsigned CMP_W  = (V_W > MAG_W) ? V_W : MAG_W;
  localparam int unsigned NPIPE  = 8;

  typedef enum logic [1:0] {
    PH_INT,
    PH_FRAC,
    PH_STOP
  } phase_e;

  // Per-sentence flags that travel with a result; neg[0] is south, neg[1] west.
  typedef struct packed {
    logic       ok;
    logic [1:0] neg;
  } ctl_t;

  logic adv;

  // Input register.
  logic              in_v_q;
  logic [CHAR_W-1:0] in_char_q;
  logic              in_last_q;

  // Sentence state.
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              hdr_ok_q, hdr_ok_d;
  logic [TOK_W-1:0]  tok_q, tok_d;
  logic              in_tok_q, in_tok_d;
  phase_e            phase_q, phase_d;
  logic [SEEN_W-1:0] lat_seen_q, lat_seen_d, lon_seen_q, lon_seen_d;
  logic [ACC_W-1:0]  lat_acc_q, lat_acc_d, lon_acc_q, lon_acc_d;
  logic              south_q, south_d, west_q, west_d;

  // Shared digit push unit.
  logic [ACC_W-1:0]  acc_sel;
  logic [ACC_W+3:0]  push_sum;
  logic [ACC_W-1:0]  push_res;
  logic [3:0]        digit;
  logic              is_digit;
  logic              push_en;
  logic              seen_inc;
  logic [SEEN_W-1:0] seen_cur;
  phase_e            phase_cur;
  logic              ok_now;

  // Conversion line.
  logic [NPIPE-1:0]  pv_q;
  ctl_t              ctl_q [NPIPE];
  logic [ACC_W-1:0]  rec_acc_q  [LANES];
  logic [SEEN_W-1:0] rec_pad_q  [LANES];
  logic [ACC_W-1:0]  pad_raw_q  [LANES];
  logic [ACC_W-1:0]  rcp_raw_q  [LANES];
  logic [Q_W-1:0]    rcp_qest_q [LANES];
  logic [ACC_W-1:0]  qu_raw_q   [LANES];
  logic [Q_W-1:0]    qu_qest_q  [LANES];
  logic [ACC_W-1:0]  qu_prod_q  [LANES];
  logic [Q_W-1:0]    cr_q_q     [LANES];
  logic [REM_W-1:0]  cr_rem_q   [LANES];
  logic [MR_W-1:0]   ml_mr_q    [LANES];
  logic [QE_W-1:0]   ml_qe7_q   [LANES];
  logic [MIN_W-1:0]  dv_min_q   [LANES];
  logic [QE_W-1:0]   dv_qe7_q   [LANES];
  logic [MAG_W-1:0]  sm_mag_q   [LANES];

  logic [ACC_W-1:0]         pad_raw_d  [LANES];
  logic [ACC_W+POW_W-1:0]   pad_prod   [LANES];
  logic [ACC_W+DIVM_W-1:0]  rcp_prod   [LANES];
  logic [ACC_W-1:0]         qu_prod_d  [LANES];
  logic [ACC_W-1:0]         rem0       [LANES];
  logic [Q_W-1:0]           cr_q_d     [LANES];
  logic [REM_W-1:0]         cr_rem_d   [LANES];
  logic [MR_W-1:0]          ml_mr_d    [LANES];
  logic [QE_W-1:0]          ml_qe7_d   [LANES];
  logic [MR_W+DIV60_W-1:0]  dv_prod    [LANES];
  logic [CMP_W-1:0]         sm_val     [LANES];
  logic [MAG_W-1:0]         sm_mag_d   [LANES];

  // Output register; the current position is the output payload.
  logic                    out_v_q;
  logic                    out_upd_q;
  logic signed [LAT_W-1:0] cur_lat_q;
  logic signed [LON_W-1:0] cur_lon_q;
  logic [LAT_W-1:0]        lat_new;
  logic [LON_W-1:0]        lon_pos, lon_new;

  // The whole line moves whenever the output register is free or being emptied.
  assign adv        = !out_v_q || out_o.ready;
  assign in_i.ready = adv;

  // Digit push: acc * 10 + digit, saturating.
  assign is_digit = (in_char_q >= CH_0) && (in_char_q <= CH_9);
  assign digit    = 4'(in_char_q - CH_0);
  assign acc_sel  = (tok_q == TOK_LAT) ? lat_acc_q : lon_acc_q;
  assign push_sum = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} + (ACC_W + 4)'(digit);
  assign push_res = (push_sum > (ACC_W + 4)'(ACC_MAX)) ? ACC_MAX : push_sum[ACC_W-1:0];

  // Character step of the sentence state.
  always_comb begin
    cnt_d      = cnt_q;
    hdr_ok_d   = hdr_ok_q;
    tok_d      = tok_q;
    in_tok_d   = in_tok_q;
    phase_d    = phase_q;
    lat_seen_d = lat_seen_q;
    lon_seen_d = lon_seen_q;
    lat_acc_d  = lat_acc_q;
    lon_acc_d  = lon_acc_q;
    south_d    = south_q;
    west_d     = west_q;
    push_en    = 1'b0;
    seen_inc   = 1'b0;
    phase_cur  = in_tok_q ? phase_q : PH_INT;
    seen_cur   = (tok_q == TOK_LAT) ? lat_seen_q : lon_seen_q;

    if (in_v_q && (cnt_q < MAX_CNT)) begin
      if (in_char_q == CH_NUL) begin
        // A zero byte ends the content.
        if (cnt_q < HDR_CNT) begin
          hdr_ok_d = 1'b0;
        end
        cnt_d = MAX_CNT;
      end else begin
        if ((cnt_q < HDR_CNT) && (in_char_q != hdr_char(cnt_q[2:0]))) begin
          hdr_ok_d = 1'b0;
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (in_char_q == CH_COMMA) begin
          // Empty tokens do not advance the token number.
          if (in_tok_q) begin
            in_tok_d = 1'b0;
            if (tok_q != TOK_LAST) begin
              tok_d = tok_q + TOK_W'(1);
            end
          end
        end else begin
          in_tok_d = 1'b1;
          phase_d  = phase_cur;
          if (!in_tok_q) begin
            if (tok_q == TOK_NS) begin
              south_d = (in_char_q == CH_S);
            end
            if (tok_q == TOK_EW) begin
              west_d = (in_char_q == CH_W);
            end
          end
          if ((tok_q == TOK_LAT) || (tok_q == TOK_LON)) begin
            unique case (phase_cur)
              PH_INT: begin
                if (is_digit) begin
                  push_en = 1'b1;
                end else if (in_char_q == CH_DOT) begin
                  phase_d = PH_FRAC;
                end else begin
                  phase_d = PH_STOP;
                end
              end
              PH_FRAC: begin
                if (is_digit) begin
                  if (seen_cur < FRAC_CNT) begin
                    push_en  = 1'b1;
                    seen_inc = 1'b1;
                  end
                end else begin
                  phase_d = PH_STOP;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    end

    if (push_en) begin
      if (tok_q == TOK_LAT) begin
        lat_acc_d = push_res;
      end else begin
        lon_acc_d = push_res;
      end
    end
    if (seen_inc) begin
      if (tok_q == TOK_LAT) begin
        lat_seen_d = lat_seen_q + SEEN_W'(1);
      end else begin
        lon_seen_d = lon_seen_q + SEEN_W'(1);
      end
    end
  end

  assign ok_now = hdr_ok_d && (cnt_d >= HDR_CNT);

  // Arithmetic of the conversion line, one step per stage.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // Pad missing fraction digits: min(acc * 10^pad, max).
      pad_prod[l]  = (ACC_W + POW_W)'(rec_acc_q[l]) *
                     (ACC_W + POW_W)'(POW10_TAB[3'(rec_pad_q[l])]);
      pad_raw_d[l] = (rec_acc_q[l] > PAD_LIM_TAB[3'(rec_pad_q[l])]) ?
                     ACC_MAX : pad_prod[l][ACC_W-1:0];
      // Degree estimate by reciprocal; low by at most one.
      rcp_prod[l]  = (ACC_W + DIVM_W)'(pad_raw_q[l]) * (ACC_W + DIVM_W)'(DIV_M);
      qu_prod_d[l] = ACC_W'(ACC_W'(rcp_qest_q[l]) * ACC_W'(UNIT));
      // Correct the estimate and keep the minutes remainder.
      rem0[l] = qu_raw_q[l] - qu_prod_q[l];
      if (rem0[l] >= ACC_W'(UNIT)) begin
        cr_q_d[l]   = qu_qest_q[l] + Q_W'(1);
        cr_rem_d[l] = REM_W'(rem0[l] - ACC_W'(UNIT));
      end else begin
        cr_q_d[l]   = qu_qest_q[l];
        cr_rem_d[l] = REM_W'(rem0[l]);
      end
      // Scale minutes and degrees to 1e-7 degrees.
      ml_mr_d[l]  = MR_W'(MR_W'(cr_rem_q[l]) * MR_W'(P7F));
      ml_qe7_d[l] = QE_W'(cr_q_q[l]) * QE_W'(E7);
      dv_prod[l]  = (MR_W + DIV60_W)'(ml_mr_q[l]) * (MR_W + DIV60_W)'(DIV60_M);
      // Sum and saturate.
      sm_val[l]   = CMP_W'(V_W'(dv_qe7_q[l]) + V_W'(dv_min_q[l]));
      sm_mag_d[l] = (sm_val[l] > CMP_W'(LIM_TAB[l])) ? LIM_TAB[l] : MAG_W'(sm_val[l]);
    end
  end

  // Apply the sign flags after saturation.
  assign lat_new = ctl_q[NPIPE-1].neg[0] ? LAT_W'(-sm_mag_q[0]) : LAT_W'(sm_mag_q[0]);
  assign lon_pos = LON_W'(sm_mag_q[1]);
  assign lon_new = ctl_q[NPIPE-1].neg[1] ? -lon_pos : lon_pos;

  // Control state: sentence state, line valid bits, output and position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q     <= 1'b0;
      cnt_q      <= '0;
      hdr_ok_q   <= 1'b1;
      tok_q      <= '0;
      in_tok_q   <= 1'b0;
      phase_q    <= PH_INT;
      lat_seen_q <= '0;
      lon_seen_q <= '0;
      lat_acc_q  <= '0;
      lon_acc_q  <= '0;
      south_q    <= 1'b0;
      west_q     <= 1'b0;
      pv_q       <= '0;
      out_v_q    <= 1'b0;
      cur_lat_q  <= '0;
      cur_lon_q  <= '0;
    end else if (adv) begin
      in_v_q  <= in_i.valid;
      pv_q    <= {pv_q[NPIPE-2:0], in_v_q && in_last_q};
      out_v_q <= pv_q[NPIPE-1];
      if (in_v_q) begin
        if (in_last_q) begin
          // End of sentence: per-sentence state returns to reset.
          cnt_q      <= '0;
          hdr_ok_q   <= 1'b1;
          tok_q      <= '0;
          in_tok_q   <= 1'b0;
          phase_q    <= PH_INT;
          lat_seen_q <= '0;
          lon_seen_q <= '0;
          lat_acc_q  <= '0;
          lon_acc_q  <= '0;
          south_q    <= 1'b0;
          west_q     <= 1'b0;
        end else begin
          cnt_q      <= cnt_d;
          hdr_ok_q   <= hdr_ok_d;
          tok_q      <= tok_d;
          in_tok_q   <= in_tok_d;
          phase_q    <= phase_d;
          lat_seen_q <= lat_seen_d;
          lon_seen_q <= lon_seen_d;
          lat_acc_q  <= lat_acc_d;
          lon_acc_q  <= lon_acc_d;
          south_q    <= south_d;
          west_q     <= west_d;
        end
      end
      if (pv_q[NPIPE-1] && ctl_q[NPIPE-1].ok) begin
        cur_lat_q <= lat_new;
        cur_lon_q <= lon_new;
      end
    end
  end

  // Payload registers of the input and of the conversion line.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_char_q <= in_i.char_byte;
      in_last_q <= in_i.last;
      ctl_q[0]  <= '{ok: ok_now, neg: {west_d, south_d}};
      for (int i = 1; i < NPIPE; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
      rec_acc_q[0] <= lat_acc_d;
      rec_acc_q[1] <= lon_acc_d;
      rec_pad_q[0] <= FRAC_CNT - lat_seen_d;
      rec_pad_q[1] <= FRAC_CNT - lon_seen_d;
      for (int l = 0; l < LANES; l++) begin
        pad_raw_q[l]  <= pad_raw_d[l];
        rcp_raw_q[l]  <= pad_raw_q[l];
        rcp_qest_q[l] <= rcp_prod[l][ACC_W +: Q_W];
        qu_raw_q[l]   <= rcp_raw_q[l];
        qu_qest_q[l]  <= rcp_qest_q[l];
        qu_prod_q[l]  <= qu_prod_d[l];
        cr_q_q[l]     <= cr_q_d[l];
        cr_rem_q[l]   <= cr_rem_d[l];
        ml_mr_q[l]    <= ml_mr_d[l];
        ml_qe7_q[l]   <= ml_qe7_d[l];
        dv_min_q[l]   <= dv_prod[l][DIV60_SH +: MIN_W];
        dv_qe7_q[l]   <= ml_qe7_q[l];
        sm_mag_q[l]   <= sm_mag_d[l];
      end
      if (pv_q[NPIPE-1]) begin
        out_upd_q <= ctl_q[NPIPE-1].ok;
      end
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.updated      = out_upd_q;
  assign out_o.latitude_e7  = cur_lat_q;
  assign out_o.longitude_e7 = cur_lon_q;

endmodule

@@ rtl/core/ngga_checker.sv @@
`include "nmea_gga_position_parser_macros.svh"

module ngga_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic                              out_updated_i,
  input logic signed [ngga_pkg::LAT_W-1:0] out_lat_i,
  input logic signed [ngga_pkg::LON_W-1:0] out_lon_i
);
  import ngga_pkg::*;

  logic signed [LAT_W-1:0] last_lat_q;
  logic signed [LON_W-1:0] last_lon_q;

  // Position last delivered, zero before the first item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_lat_q <= '0;
      last_lon_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      last_lat_q <= out_lat_i;
      last_lon_q <= out_lon_i;
    end
  end

  `NGGA_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_updated_i) && $stable(out_lat_i) && $stable(out_lon_i), "stalled result item changed")
  `NGGA_ASSERT_NOW(a_ready_when_empty, !out_valid_i && !in_valid_i || !out_valid_i, in_ready_i, "input stalled while the output is empty")
  `NGGA_ASSERT_NOW(a_reject_keeps_position, out_valid_i && !out_updated_i, out_lat_i == last_lat_q && out_lon_i == last_lon_q, "rejected sentence moved the position")
  `NGGA_ASSERT_NOW(a_position_range, out_valid_i, out_lat_i <= LAT_RANGE && out_lat_i >= -LAT_RANGE && out_lon_i <= LON_RANGE && out_lon_i >= -LON_RANGE, "position out of range")

endmodule

bind nmea_gga_position_parser ngga_checker u_ngga_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_updated_i(out_o.updated),
  .out_lat_i    (out_o.latitude_e7),
  .out_lon_i    (out_o.longitude_e7)
);

@@ tb/nmea_gga_position_parser_tb.sv @@
module nmea_gga_position_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ngga_pkg::*;

  localparam int unsigned MAX_CHARS        = MAX_CHARS_DEF;
  localparam int unsigned FRAC_DIGITS      = FRAC_DIGITS_DEF;
  localparam int unsigned IDLE_LIMIT       = 2000;
  localparam int unsigned HOLD_OFF_CYCLES  = 400;
  localparam int unsigned RANDOM_CHARS     = 1550;
  localparam int unsigned MIN_RANDOM_LINES = 40;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned DRAIN_CYCLES     = 30;

  localparam logic [CHAR_W-1:0] GGA_HDR [HDR_LEN] = '{CH_DOLLAR, CH_G, CH_P, CH_G, CH_G, CH_A};

  typedef enum logic [1:0] {PH_INT, PH_FRAC, PH_STOP} num_phase_e;

  typedef struct {
    logic                    updated;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } fix_t;

  logic clk_i;
  logic rst_ni;

  ngga_in_if  char_if ();
  ngga_out_if pos_if ();

  nmea_gga_position_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_if),
    .out_o  (pos_if)
  );

  // Sentence state of the predictor.
  logic [6:0]              sent_chars;
  logic                    hdr_good;
  logic [TOK_W-1:0]        tok_idx;
  logic                    in_tok;
  num_phase_e              num_phase;
  logic [2:0]              frac_seen;
  logic [ACC_W-1:0]        lat_raw;
  logic [ACC_W-1:0]        lon_raw;
  logic                    lat_south;
  logic                    lon_west;
  logic signed [LAT_W-1:0] fix_lat;
  logic signed [LON_W-1:0] fix_lon;

  fix_t              pending_fix_q [$];
  logic [CHAR_W-1:0] line_q [$];
  int unsigned       fault_count   = 0;
  int unsigned       chars_sent    = 0;
  int unsigned       burst_left    = 0;
  int unsigned       hold_off_req  = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Position predictor
  // ---------------------------------------------------------------------------

  task automatic reset_sentence_state();
    sent_chars = '0;
    hdr_good   = 1'b1;
    tok_idx    = '0;
    in_tok     = 1'b0;
    num_phase  = PH_INT;
    frac_seen  = '0;
    lat_raw    = '0;
    lon_raw    = '0;
    lat_south  = 1'b0;
    lon_west   = 1'b0;
  endtask

  // Shifts one decimal digit into a raw value, saturating at all ones.
  function automatic logic [ACC_W-1:0] raw_push(input logic [ACC_W-1:0] acc,
                                                 input int unsigned digit);
    longint unsigned r;
    r = acc;
    r = r * 10 + digit;
    if (r > ACC_MAX) r = ACC_MAX;
    return r[ACC_W-1:0];
  endfunction

  function automatic bit coord_token();
    return tok_idx == TOK_LAT || tok_idx == TOK_LON;
  endfunction

  task automatic digit_into(input int unsigned digit);
    if (tok_idx == TOK_LAT) lat_raw = raw_push(lat_raw, digit);
    else if (tok_idx == TOK_LON) lon_raw = raw_push(lon_raw, digit);
  endtask

  // Closing a coordinate token pads the missing fraction digits with zeros.
  task automatic close_field();
    if (in_tok && coord_token()) begin
      for (int i = frac_seen; i < FRAC_DIGITS; i++) digit_into(0);
    end
    in_tok = 1'b0;
  endtask

  task automatic scan_char(input logic [CHAR_W-1:0] c);
    bit is_digit;
    is_digit = c >= CH_0 && c <= CH_9;
    if (c == CH_COMMA) begin
      if (in_tok) begin
        close_field();
        if (tok_idx != TOK_LAST) tok_idx++;
      end
      return;
    end
    // The first character of a token opens it and settles the direction flags.
    if (!in_tok) begin
      in_tok    = 1'b1;
      num_phase = PH_INT;
      frac_seen = '0;
      if (tok_idx == TOK_NS) lat_south = c == CH_S;
      if (tok_idx == TOK_EW) lon_west  = c == CH_W;
    end
    if (!coord_token()) return;
    case (num_phase)
      PH_INT: begin
        if (is_digit) digit_into(c - CH_0);
        else if (c == CH_DOT) num_phase = PH_FRAC;
        else num_phase = PH_STOP;
      end
      PH_FRAC: begin
        if (is_digit) begin
          if (frac_seen < FRAC_DIGITS) begin
            digit_into(c - CH_0);
            frac_seen++;
          end
        end else begin
          num_phase = PH_STOP;
        end
      end
      default: ;
    endcase
  endtask

  // Degrees and minutes to 1e-7 degrees, truncated and clipped to the limit.
  function automatic longint unsigned coord_e7(input logic [ACC_W-1:0] raw,
                                               input longint unsigned lim);
    longint unsigned frac_scale, deg_unit, deg, minraw, mag;
    frac_scale = 1;
    for (int i = 0; i < FRAC_DIGITS; i++) frac_scale *= 10;
    deg_unit = 100 * frac_scale;
    deg      = raw / deg_unit;
    minraw   = raw - deg * deg_unit;
    mag      = deg * 64'd10000000 + minraw * (64'd10000000 / frac_scale) / 60;
    return (mag > lim) ? lim : mag;
  endfunction

  task automatic predict_char(input logic [CHAR_W-1:0] c, input logic is_last);
    bit     ok;
    longint coord;
    if (sent_chars < MAX_CHARS) begin
      if (c == CH_NUL) begin
        if (sent_chars < HDR_LEN) hdr_good = 1'b0;
        sent_chars = MAX_CHARS;
      end else begin
        if (sent_chars < HDR_LEN && c != GGA_HDR[sent_chars]) hdr_good = 1'b0;
        scan_char(c);
        sent_chars++;
      end
    end
    if (!is_last) return;
    close_field();
    ok = hdr_good && sent_chars >= HDR_LEN;
    if (ok) begin
      coord = coord_e7(lat_raw, LAT_RANGE);
      if (lat_south) coord = -coord;
      fix_lat = coord[LAT_W-1:0];
      coord = coord_e7(lon_raw, LON_RANGE);
      if (lon_west) coord = -coord;
      fix_lon = coord[LON_W-1:0];
    end
    pending_fix_q.push_back('{updated: ok, lat: fix_lat, lon: fix_lon});
    reset_sentence_state();
  endtask

  // ---------------------------------------------------------------------------
  // Character sender
  // ---------------------------------------------------------------------------

  // Offers one character, with bursts of random length and idle gaps between them.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        char_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    char_if.valid     <= 1'b1;
    char_if.char_byte <= c;
    char_if.last      <= is_last;
    do @(posedge clk_i); while (!char_if.ready);
    predict_char(c, is_last);
    chars_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  // Sends the assembled sentence, marking its final character as last.
  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_char(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_line();
  endtask

  task automatic add_digits(input int unsigned n);
    for (int i = 0; i < n; i++) line_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
  endtask

  // A coordinate: integer digits, an optional fraction and now and then junk.
  task automatic add_number();
    int unsigned n_int;
    n_int = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 5);
    add_digits(n_int);
    if ($urandom_range(0, 4) != 0) begin
      add_text(".");
      add_digits($urandom_range(0, FRAC_DIGITS + 3));
    end
    if ($urandom_range(0, 9) == 0) begin
      line_q.push_back(8'($urandom_range(32, 126)));
      add_digits($urandom_range(0, 3));
    end
  endtask

  task automatic add_direction();
    case ($urandom_range(0, 5))
      0: add_text("N");
      1: line_q.push_back(CH_S);
      2: add_text("E");
      3: line_q.push_back(CH_W);
      4: line_q.push_back(8'($urandom_range(33, 126)));
      default: begin
        line_q.push_back(8'($urandom_range(33, 126)));
        line_q.push_back($urandom_range(0, 1) ? CH_S : CH_W);
      end
    endcase
  endtask

  // A GGA sentence with random fields; a stretched one runs past the character limit.
  task automatic add_gga_body(input bit stretch);
    int unsigned n_fields, target;
    add_text("$GPGGA");
    n_fields = $urandom_range(0, 9);
    for (int f = 1; f <= n_fields; f++) begin
      add_text(",");
      if ($urandom_range(0, 7) == 0) add_text(",");
      if ($urandom_range(0, 9) == 0) continue;
      case (f)
        1:       add_digits(stretch ? $urandom_range(90, 125) : $urandom_range(0, 6));
        2, 4:    add_number();
        3, 5:    add_direction();
        default: add_digits($urandom_range(1, 4));
      endcase
    end
    if (stretch) begin
      target = $urandom_range(MAX_CHARS + 3, MAX_CHARS + 40);
      while (line_q.size() < target) begin
        line_q.push_back(CH_COMMA);
        add_digits($urandom_range(1, 8));
      end
    end
    if ($urandom_range(0, 3) == 0) add_text("*47");
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, result checker and watchdog
  // ---------------------------------------------------------------------------

  // The receiver stalls on a random ready mask that is redrawn over the run, at times all ones;
  // a hold-off request keeps it stalled for a whole stretch.
  initial begin
    int unsigned hold_left, cyc;
    logic [7:0]  ready_mask;
    hold_left  = 0;
    cyc        = 0;
    ready_mask = 8'hFF;
    pos_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (cyc % 128 == 0) begin
        ready_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      cyc++;
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pos_if.ready <= 1'b0;
      end else begin
        pos_if.ready <= ready_mask[cyc % 8];
      end
    end
  end

  task automatic note_fault(input string what, input longint want, input longint got);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Each accepted result is compared with the oldest expected position.
  always @(posedge clk_i) begin
    fix_t want;
    if (rst_ni && pos_if.valid && pos_if.ready) begin
      if (pending_fix_q.size() == 0) begin
        note_fault("unexpected result", 0, 1);
      end else begin
        want = pending_fix_q.pop_front();
        if (pos_if.updated !== want.updated) note_fault("updated", want.updated, pos_if.updated);
        if (pos_if.latitude_e7 !== want.lat) begin
          note_fault("latitude_e7", want.lat, pos_if.latitude_e7);
        end
        if (pos_if.longitude_e7 !== want.lon) begin
          note_fault("longitude_e7", want.lon, pos_if.longitude_e7);
        end
      end
    end
  end

  // Ends the run when neither channel has moved an item for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((char_if.valid && char_if.ready) || (pos_if.valid && pos_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The bare header, then typical northern, southern and western fixes.
  task automatic test_basic_fixes();
    send_text("$GPGGA");
    send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
    send_text("$GPGGA,092750,5321.6802,S,00630.3372,W,1,8,1.03,61.7,M");
  endtask

  // Empty fields do not count, so runs of commas shift the token numbers.
  task automatic test_empty_fields();
    send_text("$GPGGA,,,4916.45,,S,,,12311.12,W,,");
    send_text("$GPGGA,,1,,4916.45,,S,,12311.12,,W,");
  endtask

  // Limits, saturation, dropped fraction digits and characters that stop the reading.
  task automatic test_number_forms();
    send_text("$GPGGA,0,9000.00000,S,18000.00000,W");
    send_text("$GPGGA,0,9959.99999,N,99999.9999999,E");
    send_text("$GPGGA,0,99999999999999,N,.5,E");
    send_text("$GPGGA,0,49x16.5,XS,-123, W");
    send_text("$GPGGA,0,4916.,S,12311.12.5,W");
  endtask

  // Wrong headers, a zero byte inside and after the header, and all-ones bytes.
  task automatic test_header_faults();
    send_text("$GPGSA,0,4916.45,S,12311.12,W");
    add_text("$GP");
    line_q.push_back(CH_NUL);
    send_text("GA,0,4916.45,S");
    send_text("$GPG");
    add_text("$GPGGA");
    line_q.push_back(CH_NUL);
    send_text(",0,4916.45,S");
    add_text("$GPGGA,0,12");
    line_q.push_back(8'hFF);
    send_text("34,S,5,W");
    line_q.push_back(8'hFF);
    send_line();
  endtask

  // Tokens beyond the last counted one, and sentences longer than the limit.
  task automatic test_long_sentences();
    send_text("$GPGGA,a,b,c,d,e,f,g,h,i,j,k");
    add_text("$GPGGA,0,4916.45,S,12311.12,W");
    while (line_q.size() < MAX_CHARS + 13) add_text(",pad");
    send_line();
    add_text("$GPGGA,");
    while (line_q.size() < MAX_CHARS - 8) add_text("1");
    send_text(",4916.45,S,12311.12,W");
  endtask

  // The receiver holds off while short sentences keep coming, so the block fills up.
  task automatic test_backpressure();
    hold_off_req = HOLD_OFF_CYCLES;
    burst_left   = 200;
    for (int i = 0; i < 25; i++) begin
      if (i % 5 == 4) send_text("x");
      else send_text("$GPGGA");
    end
  endtask

  // Mostly well-formed sentences with random content, the rest noise and broken ones.
  task automatic test_random_sentences();
    int unsigned first_char, lines, kind, pos;
    first_char = chars_sent;
    lines      = 0;
    while (chars_sent - first_char < RANDOM_CHARS || lines < MIN_RANDOM_LINES) begin
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        add_gga_body(kind == 19);
        if (kind == 2) begin
          pos = $urandom_range(0, HDR_LEN - 1);
          line_q[pos] = 8'($urandom_range(0, 255));
        end else if (kind == 3) begin
          pos = $urandom_range(0, line_q.size());
          line_q.insert(pos, CH_NUL);
        end
      end
      send_line();
      lines++;
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    char_if.valid     <= 1'b0;
    char_if.char_byte <= CH_NUL;
    char_if.last      <= 1'b0;
    reset_sentence_state();
    fix_lat = '0;
    fix_lon = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_fixes();
    test_empty_fields();
    test_number_forms();
    test_header_faults();
    test_long_sentences();
    test_backpressure();
    test_random_sentences();

    // Let every expected position arrive, then allow for stray results.
    char_if.valid <= 1'b0;
    while (pending_fix_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
